/* sv/isa_pkg.sv */
// shared types and constants for the id slot allocator
`timescale 1ns / 1ps

package isa_pkg;

   localparam int ID_W       = 32;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int SLOT_IDX_W = 6;
   localparam int RSP_DATA_W = 40;

   // request kinds, any code other than allocate or release acts as lookup
   localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC_CHK,
      S_MOD_MUL,
      S_MOD_SUB,
      S_LOOK_RD,
      S_LOOK_CHK
   } isa_state_type;

   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic read_cur;
      logic probe_step;
      logic alloc_full;
      logic alloc_grant;
      logic mod_mul;
      logic mod_sub;
      logic read_look;
      logic look_done;
   } isa_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_alloc;
      logic out_free;
      logic slot_busy;
      logic lap_done;
   } isa_stat_type;

endpackage

/* sv/isa_ctrl.sv */
// controller state machine of the id slot allocator
`timescale 1ns / 1ps

module isa_ctrl import isa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  isa_stat_type stat,
   output isa_cmd_type  cmd
);

   isa_state_type state_ff;
   isa_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               if (stat.req_alloc) begin
                  cmd.read_cur = 1'b1;
                  state_in     = S_ALLOC_CHK;
               end else begin
                  state_in = S_MOD_MUL;
               end
            end
         end
         S_ALLOC_CHK: begin
            // occupied slots advance the counter without touching the output
            priority if (stat.slot_busy && !stat.lap_done) begin
               cmd.probe_step = 1'b1;
            end else if (stat.out_free) begin
               if (stat.slot_busy) begin
                  cmd.alloc_full = 1'b1;
               end else begin
                  cmd.alloc_grant = 1'b1;
               end
               state_in = S_IDLE;
            end else begin
               state_in = S_ALLOC_CHK;
            end
         end
         S_MOD_MUL: begin
            cmd.mod_mul = 1'b1;
            state_in    = S_MOD_SUB;
         end
         S_MOD_SUB: begin
            cmd.mod_sub = 1'b1;
            state_in    = S_LOOK_RD;
         end
         S_LOOK_RD: begin
            cmd.read_look = 1'b1;
            state_in      = S_LOOK_CHK;
         end
         S_LOOK_CHK: begin
            if (stat.out_free) begin
               cmd.look_done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

/* sv/isa_datapath.sv */
// datapath of the id slot allocator: counter, slot table, modulo unit, result register
`timescale 1ns / 1ps

module isa_datapath import isa_pkg::*; #(
   parameter int SLOTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  isa_cmd_type           cmd,
   output isa_stat_type          stat,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [ID_W-1:0]       req_id,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ID_W-1:0]       rsp_new_id,
   output logic [SLOT_IDX_W-1:0] rsp_slot
);

   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int REM_W   = SLOT_W + 1;
   localparam int ENTRY_W = ID_W + 1;
   localparam int PROD_W  = 2 * ID_W;

   localparam logic [ID_W-1:0]   RECIP         = ID_W'((64'd1 << ID_W) / SLOTS);
   localparam logic [ID_W-1:0]   SLOTS_ID      = ID_W'(SLOTS);
   localparam logic [REM_W-1:0]  SLOTS_REM     = REM_W'(SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_LAST     = SLOT_W'(SLOTS - 1);
   localparam logic [ID_W-1:0]   COUNTER_RESET = ID_W'(1);
   localparam logic [SLOT_W-1:0] CSLOT_RESET   = SLOT_W'(1);

   // slot table entry: owner id with the occupied bit on top
   logic [ENTRY_W-1:0] slot_mem [SLOTS];

   logic [ID_W-1:0]     counter_ff;
   logic [SLOT_W-1:0]   cslot_ff;
   logic [SLOT_W-1:0]   cslot_next;
   logic [SLOT_W-1:0]   start_ff;
   logic [SLOT_W-1:0]   clr_idx_ff;
   logic [ID_W-1:0]     id_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [ID_W-1:0]     q_est_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [SLOT_W-1:0]   lslot_ff;
   logic [ENTRY_W-1:0]  rd_data_ff;

   logic [PROD_W-1:0]   recip_prod;
   logic [PROD_W-1:0]   qs_prod;
   logic [ID_W-1:0]     rem_diff;
   logic [SLOT_W-1:0]   look_slot;

   logic                rd_en;
   logic [SLOT_W-1:0]   rd_addr;
   logic                wr_en;
   logic [SLOT_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0]  wr_data;

   logic                rd_valid;
   logic [ID_W-1:0]     rd_owner;
   logic                hit;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ID_W-1:0]     rsp_new_id_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                emit;
   logic [STATUS_W-1:0] rsp_status_in;
   logic [ID_W-1:0]     rsp_new_id_in;
   logic [SLOT_W-1:0]   rsp_slot_in;
   logic [SLOT_W+SLOT_IDX_W-1:0] rsp_slot_wide;

   assign rd_valid = rd_data_ff[ID_W];
   assign rd_owner = rd_data_ff[ID_W-1:0];
   assign hit      = rd_valid && (rd_owner == id_ff);

   // counter slot follows counter mod SLOTS, also across the 32-bit wrap
   always_comb begin
      priority if (counter_ff == '1) begin
         cslot_next = '0;
      end else if (cslot_ff == SLOT_LAST) begin
         cslot_next = '0;
      end else begin
         cslot_next = cslot_ff + 1'b1;
      end
   end

   // id mod SLOTS: reciprocal estimate is at most one short, one correction
   assign recip_prod = {{ID_W{1'b0}}, id_ff} * {{ID_W{1'b0}}, RECIP};
   assign qs_prod    = {{ID_W{1'b0}}, q_est_ff} * {{ID_W{1'b0}}, SLOTS_ID};
   assign rem_diff   = id_ff - qs_prod[ID_W-1:0];
   assign look_slot  = (rem_ff >= SLOTS_REM) ? SLOT_W'(rem_ff - SLOTS_REM)
                                             : rem_ff[SLOT_W-1:0];

   always_comb begin
      rd_en   = cmd.read_cur | cmd.probe_step | cmd.read_look;
      rd_addr = cslot_ff;
      priority if (cmd.probe_step) begin
         rd_addr = cslot_next;
      end else if (cmd.read_look) begin
         rd_addr = look_slot;
      end else begin
         rd_addr = cslot_ff;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_idx_ff;
      wr_data = '0;
      priority if (cmd.clear_step) begin
         wr_en = 1'b1;
      end else if (cmd.alloc_grant) begin
         wr_en   = 1'b1;
         wr_addr = cslot_ff;
         wr_data = {1'b1, counter_ff};
      end else if (cmd.look_done && hit && (kind_ff == KIND_RELEASE)) begin
         wr_en   = 1'b1;
         wr_addr = lslot_ff;
         wr_data = {1'b0, rd_owner};
      end else begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= COUNTER_RESET;
         cslot_ff   <= CSLOT_RESET;
         clr_idx_ff <= '0;
      end else begin
         if (cmd.probe_step || cmd.alloc_full || cmd.alloc_grant) begin
            counter_ff <= counter_ff + 1'b1;
            cslot_ff   <= cslot_next;
         end
         if (cmd.clear_step) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         id_ff    <= req_id;
         kind_ff  <= req_kind;
         start_ff <= cslot_ff;
      end
      if (cmd.mod_mul) begin
         q_est_ff <= recip_prod[PROD_W-1:ID_W];
      end
      if (cmd.mod_sub) begin
         rem_ff <= rem_diff[REM_W-1:0];
      end
      if (cmd.read_look) begin
         lslot_ff <= look_slot;
      end
   end

   // result register
   always_comb begin
      emit          = cmd.alloc_grant | cmd.alloc_full | cmd.look_done;
      rsp_status_in = STATUS_OK;
      rsp_new_id_in = '0;
      rsp_slot_in   = lslot_ff;
      priority if (cmd.alloc_grant) begin
         rsp_new_id_in = counter_ff;
         rsp_slot_in   = cslot_ff;
      end else if (cmd.alloc_full) begin
         rsp_status_in = STATUS_FULL;
         rsp_slot_in   = start_ff;
      end else if (!hit) begin
         rsp_status_in = STATUS_NOT_FOUND;
      end else begin
         rsp_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_new_id_ff <= rsp_new_id_in;
         rsp_slot_ff   <= rsp_slot_in;
      end
   end

   assign rsp_slot_wide = {{SLOT_IDX_W{1'b0}}, rsp_slot_ff};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_new_id = rsp_new_id_ff;
   assign rsp_slot   = rsp_slot_wide[SLOT_IDX_W-1:0];

   assign stat.clear_last = (clr_idx_ff == SLOT_LAST);
   assign stat.req_alloc  = (req_kind == KIND_ALLOC);
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;
   assign stat.slot_busy  = rd_valid;
   assign stat.lap_done   = (cslot_next == start_ff);

endmodule

/* sv/id_slot_allocator_core.sv */
// top level of the id slot allocator
`timescale 1ns / 1ps
//
//  channel | dir | tdata                          | tuser
//  --------+-----+--------------------------------+---------------
//  req_    | in  | id[31:0]                       | kind[1:0]
//  rsp_    | out | new_id[31:0], slot_index[37:32] | status[1:0]
//
//  lookup and release run a modulo multiply, correction and one registered table
//  read. allocate skips occupied slots one by one; a full table ends after a whole
//  lap of the table. one table read port sets the pace.
//  after reset the table is swept clean, req_tready stays low.
//  a result waiting in the output register does not block the next request;
//  only the final step of a request waits for rsp_tready.

module id_slot_allocator_core import isa_pkg::*; #(
   parameter int SLOTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ID_W-1:0]       req_tdata,  // id
   input  logic [KIND_W-1:0]     req_tuser,  // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // new_id, slot_index, zero pad
   output logic [STATUS_W-1:0]   rsp_tuser   // status
);

   localparam int RSP_PAD_W = RSP_DATA_W - SLOT_IDX_W - ID_W;

   isa_cmd_type           cmd;
   isa_stat_type          stat;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ID_W-1:0]       rsp_new_id;
   logic [SLOT_IDX_W-1:0] rsp_slot;

   isa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   isa_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_kind   (req_tuser),
      .req_id     (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_new_id (rsp_new_id),
      .rsp_slot   (rsp_slot)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_slot, rsp_new_id};
   assign rsp_tuser = rsp_status;

endmodule

/* sv/isa_checker.sv */
// port-level assertions for the id slot allocator, bound to the top level
`timescale 1ns / 1ps

module isa_checker import isa_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser
);

   // table sweep starts right after reset, no request taken then
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request port ready right after reset");

   // one request in flight at a time
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in flight");

   // failed requests grant no identifier
   a_fail_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_OK) |-> rsp_tdata[ID_W-1:0] == '0)
      else $error("identifier granted on failed request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind id_slot_allocator_core isa_checker u_isa_checker (.*);
